@@ hw/rtl/rad_pkg.sv @@
`timescale 1ns / 1ps

package rad_pkg;

   // Limit on the number of output pixels in one row.
   localparam int MAX_WIDTH = 4096;

   localparam int CNT_W    = 13;
   localparam int INDEX_W  = 12;
   localparam int UNITS_W  = 21;
   localparam int WEIGHT_W = 16;
   localparam int PIECE_W  = 9;
   localparam int SUM_W    = 16;
   localparam int NUM_LANES = 4;
   localparam int ADDR_W   = 4;

   localparam logic [PIECE_W-1:0] PIXEL_UNITS = 9'h100;
   localparam logic [7:0]         BYTE_MAX    = 8'hFF;
   localparam logic [SUM_W-1:0]   SUM_MAX     = 16'hFFFF;

   localparam logic [1:0] REG_OUT_WIDTH   = 2'd0;
   localparam logic [1:0] REG_STEP_RATIO  = 2'd1;
   localparam logic [1:0] REG_UNIT_WEIGHT = 2'd2;
   localparam logic [1:0] REG_ADD_MODE    = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_WEIGHT = 3'b010,
      S_SUM    = 3'b100
   } state_type;

   // Per-pixel control that every channel lane sees in the accumulate cycle.
   typedef struct packed {
      logic [WEIGHT_W-1:0] w_first;
      logic [WEIGHT_W-1:0] w_rest;
      logic                clear;
      logic                active;
      logic                emit;
   } lane_ctrl_type;

   function automatic logic [7:0] sat_add_byte(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[8] ? BYTE_MAX : s[7:0];
   endfunction

endpackage

@@ hw/rtl/rad_ctrl.sv @@
`timescale 1ns / 1ps

module rad_ctrl import rad_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic                commit,
   input  logic                row_start,
   input  logic [CNT_W-1:0]    out_width,
   input  logic [UNITS_W-1:0]  step_ratio,
   input  logic [WEIGHT_W-1:0] unit_weight,
   output lane_ctrl_type       ctrl,
   output logic [INDEX_W-1:0]  out_index,
   output logic                row_done
);

   logic [UNITS_W-1:0]  units_left_ff, units_next_ff, units_next_in;
   logic [CNT_W-1:0]    outputs_done_ff, done_next_ff, done_next_in;
   lane_ctrl_type       ctrl_ff, ctrl_in;
   logic [INDEX_W-1:0]  index_ff;
   logic                last_ff, last_in;

   logic [UNITS_W-1:0]  eff_step, units;
   logic [CNT_W-1:0]    eff_width, done, done_inc;
   logic                whole;
   logic [PIECE_W-1:0]  piece_first, piece_rest;
   logic [24:0]         prod_first, prod_rest;

   always_comb begin
      eff_step  = (step_ratio < UNITS_W'(PIXEL_UNITS)) ? UNITS_W'(PIXEL_UNITS) : step_ratio;
      eff_width = (out_width > CNT_W'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH) : out_width;
      units     = row_start ? eff_step : units_left_ff;
      done      = row_start ? '0 : outputs_done_ff;
      done_inc  = done + CNT_W'(1);
      whole     = units > UNITS_W'(PIXEL_UNITS);

      // A pixel that reaches the output boundary is split in two pieces.
      piece_first = whole ? PIXEL_UNITS : units[PIECE_W-1:0];
      piece_rest  = PIXEL_UNITS - piece_first;
      prod_first  = 25'(piece_first) * 25'(unit_weight);
      prod_rest   = 25'(piece_rest) * 25'(unit_weight);

      ctrl_in.w_first = prod_first[23:8];
      ctrl_in.w_rest  = prod_rest[23:8];
      ctrl_in.clear   = row_start;
      ctrl_in.active  = done < eff_width;
      ctrl_in.emit    = ctrl_in.active && !whole;

      if (!ctrl_in.active) begin
         units_next_in = units;
      end else if (ctrl_in.emit) begin
         units_next_in = eff_step - UNITS_W'(piece_rest);
      end else begin
         units_next_in = units - UNITS_W'(PIXEL_UNITS);
      end
      done_next_in = ctrl_in.emit ? done_inc : done;
      last_in      = done_inc == eff_width;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ctrl_ff       <= ctrl_in;
         units_next_ff <= units_next_in;
         done_next_ff  <= done_next_in;
         index_ff      <= done[INDEX_W-1:0];
         last_ff       <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         units_left_ff   <= UNITS_W'(PIXEL_UNITS);
         outputs_done_ff <= '0;
      end else if (commit) begin
         units_left_ff   <= units_next_ff;
         outputs_done_ff <= done_next_ff;
      end
   end

   assign ctrl      = ctrl_ff;
   assign out_index = index_ff;
   assign row_done  = last_ff;

   a_units_nonzero: assert property (@(posedge clock) disable iff (reset)
      units_left_ff != '0)
      else $error("units left in the current output dropped to zero");

   a_done_bounded: assert property (@(posedge clock) disable iff (reset)
      outputs_done_ff <= CNT_W'(MAX_WIDTH))
      else $error("output count ran past the width limit");

endmodule

@@ hw/rtl/rad_lane.sv @@
`timescale 1ns / 1ps

module rad_lane import rad_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          commit,
   input  lane_ctrl_type ctrl,
   input  logic          add_mode,
   input  logic [7:0]    src_byte,
   input  logic [7:0]    dest_byte,
   output logic [7:0]    out_byte
);

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [SUM_W-1:0] base, acc_sat;
   logic [23:0]      prod_first, prod_rest;
   logic [SUM_W:0]   acc;

   always_comb begin
      base       = ctrl.clear ? '0 : sum_ff;
      prod_first = 24'(src_byte) * 24'(ctrl.w_first);
      prod_rest  = 24'(src_byte) * 24'(ctrl.w_rest);
      acc        = {1'b0, base} + {1'b0, prod_first[SUM_W-1:0]};
      acc_sat    = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
      out_byte   = add_mode ? sat_add_byte(acc_sat[15:8], dest_byte) : acc_sat[15:8];

      // After an output completes, the sum restarts with the leftover piece.
      if (!ctrl.active) begin
         sum_in = base;
      end else if (ctrl.emit) begin
         sum_in = prod_rest[SUM_W-1:0];
      end else begin
         sum_in = acc_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (commit) begin
         sum_ff <= sum_in;
      end
   end

endmodule

@@ hw/rtl/rad_merge.sv @@
`timescale 1ns / 1ps

module rad_merge import rad_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic [31:0]          pixel,
   input  logic [INDEX_W-1:0]   index,
   input  logic                 last,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [47:0]          rsp_tdata,
   output logic                 rsp_tlast
);

   logic                valid_ff;
   logic [31:0]         pixel_ff;
   logic [INDEX_W-1:0]  index_ff;
   logic                last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pixel_ff <= pixel;
         index_ff <= index;
         last_ff  <= last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'b0, index_ff, pixel_ff};
   assign rsp_tlast  = last_ff;

endmodule

@@ hw/rtl/row_area_average_downscaler.sv @@
`timescale 1ns / 1ps

// Horizontal area-averaging downscaler for one row of ARGB pixels at a time.
// Source pixels enter on the req channel: tdata holds the source pixel and the
// destination pixel, tuser flags the first pixel of a row. Averaged output
// pixels leave on the rsp channel with their position in the row; tlast marks
// the last output of the row. A source pixel yields zero or one output.
// Each accepted pixel passes through the weight step, which multiplies the
// weights of its two pieces, and then the accumulate step, in which the four
// channel lanes multiply and accumulate. A new pixel can be taken in the same
// cycle that the previous one finishes, and not before; an output is written
// to the output register when its pixel commits at the end of accumulation.
// The output register holds a finished pixel while the receiver stalls, and
// the block keeps taking pixels until one more output is ready; then req_tready
// stays low until the waiting output is taken.
// Reset clears the sums and the output count and acts as the start of a row
// with a step of one pixel. The user writes registers over the csr port only
// while the block is idle; the block itself does not enforce this.
module row_area_average_downscaler import rad_pkg::*; (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [63:0]       req_tdata,   // src_pixel [31:0], dest_pixel [63:32]
   input  logic              req_tuser,   // row_start

   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [47:0]       rsp_tdata,   // out_pixel [31:0], out_index [43:32]
   output logic              rsp_tlast,   // row_done

   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [CNT_W-1:0]    out_width_ff;
   logic [UNITS_W-1:0]  step_ratio_ff;
   logic [WEIGHT_W-1:0] unit_weight_ff;
   logic                add_mode_ff;

   state_type           state_ff, state_in;
   logic [31:0]         src_ff, dest_ff;
   logic                row_start_ff;

   lane_ctrl_type       ctrl;
   logic [INDEX_W-1:0]  out_index;
   logic                row_done;
   logic [31:0]         lane_pixel;
   logic                req_xfer, cfg_write, can_commit, commit, load;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_width_ff   <= CNT_W'(1);
         step_ratio_ff  <= UNITS_W'(PIXEL_UNITS);
         unit_weight_ff <= WEIGHT_W'(PIXEL_UNITS);
         add_mode_ff    <= 1'b0;
      end else if (cfg_write) begin
         case (csr_paddr[3:2])
            REG_OUT_WIDTH:   out_width_ff   <= csr_pwdata[CNT_W-1:0];
            REG_STEP_RATIO:  step_ratio_ff  <= csr_pwdata[UNITS_W-1:0];
            REG_UNIT_WEIGHT: unit_weight_ff <= csr_pwdata[WEIGHT_W-1:0];
            REG_ADD_MODE:    add_mode_ff    <= csr_pwdata[0];
            default:         ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_OUT_WIDTH:   csr_prdata = 32'(out_width_ff);
         REG_STEP_RATIO:  csr_prdata = 32'(step_ratio_ff);
         REG_UNIT_WEIGHT: csr_prdata = 32'(unit_weight_ff);
         REG_ADD_MODE:    csr_prdata = 32'(add_mode_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // Sequencing: weights in the S_WEIGHT state, lane accumulate in the S_SUM state that follows it.
   assign can_commit = !ctrl.emit || !rsp_tvalid || rsp_tready;
   assign commit     = (state_ff == S_SUM) && can_commit;
   assign load       = state_ff == S_WEIGHT;
   assign req_tready = (state_ff == S_IDLE) || commit;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      case (state_ff)
         S_IDLE:   state_in = req_xfer ? S_WEIGHT : S_IDLE;
         S_WEIGHT: state_in = S_SUM;
         S_SUM: begin
            if (!can_commit) begin
               state_in = S_SUM;
            end else begin
               state_in = req_xfer ? S_WEIGHT : S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         src_ff       <= req_tdata[31:0];
         dest_ff      <= req_tdata[63:32];
         row_start_ff <= req_tuser;
      end
   end

   rad_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .commit      (commit),
      .row_start   (row_start_ff),
      .out_width   (out_width_ff),
      .step_ratio  (step_ratio_ff),
      .unit_weight (unit_weight_ff),
      .ctrl        (ctrl),
      .out_index   (out_index),
      .row_done    (row_done)
   );

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      rad_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .commit    (commit),
         .ctrl      (ctrl),
         .add_mode  (add_mode_ff),
         .src_byte  (src_ff[8*l +: 8]),
         .dest_byte (dest_ff[8*l +: 8]),
         .out_byte  (lane_pixel[8*l +: 8])
      );
   end

   rad_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (commit && ctrl.emit),
      .pixel      (lane_pixel),
      .index      (out_index),
      .last       (row_done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_no_accept_mid_pixel: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> state_ff != S_WEIGHT)
      else $error("pixel transfer while the weight stage is busy");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM && ctrl.emit && rsp_tvalid && !rsp_tready) |-> !commit && !req_tready)
      else $error("finished pixel would overwrite a stalled output");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      (commit && ctrl.emit) |=> rsp_tvalid)
      else $error("completed output did not reach the output register");

endmodule
